### sv/pdiw_pkg.sv
// Shared constants and types for the PID deadband/integral-window unit.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package pdiw_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	localparam int GAIN_W        = 16;
	localparam int DB_W          = 15;
	localparam int SUM_W         = 32;
	localparam int DRIVE_W       = 32;
	localparam int WINDOW_FACTOR = 6;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	typedef enum logic [1:0] {
		REG_KP       = 2'd0,
		REG_KI       = 2'd1,
		REG_KD       = 2'd2,
		REG_DEADBAND = 2'd3
	} reg_idx_t;

endpackage

`default_nettype wire

### sv/pid_deadband_integral_window_unit.sv
// Inputs pass through registered stages 1 to 4. Throughput: one transaction
// per cycle when not stalled; the integral and last error update in stage 2, a single
// 32-bit add and saturate, so back-to-back samples see each other's state.
// Reset: arst_n clears gains, deadband, integral sum, last error and all stage valids.
// Any empty stage lets input transactions in while a result waits at the output.
// Depends on pdiw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pid_deadband_integral_window_unit #(
	parameter int DATA_WIDTH = pdiw_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = pdiw_pkg::FRAC_BITS_DEF,
	localparam int IN_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// s_tdata: setpoint [DATA_WIDTH-1:0], measurement [2*DATA_WIDTH-1:DATA_WIDTH], zero pad
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [IN_TDATA_W-1:0]           s_tdata,
	// m_tdata: drive [31:0]
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [pdiw_pkg::DRIVE_W-1:0]         m_tdata,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [pdiw_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [pdiw_pkg::APB_DATA_W-1:0] pwdata,
	output logic [pdiw_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready
);
	import pdiw_pkg::*;

	localparam int ERR_W   = DATA_WIDTH + 1;
	localparam int WIN_W   = DB_W + 3;
	localparam int CMP_W   = ((ERR_W > WIN_W) ? ERR_W : WIN_W) + 1;
	localparam int ACC_W   = ((ERR_W > SUM_W) ? ERR_W : SUM_W) + 1;
	localparam int DER_W   = DATA_WIDTH + 2;
	localparam int PP_W    = GAIN_W + ERR_W;
	localparam int PI_W    = GAIN_W + SUM_W;
	localparam int PD_W    = GAIN_W + DER_W;
	localparam int PMAX_A  = (PP_W > PI_W) ? PP_W : PI_W;
	localparam int PMAX_W  = (PMAX_A > PD_W) ? PMAX_A : PD_W;
	localparam int DACC_W  = PMAX_W + 2;

	// configuration
	logic [GAIN_W-1:0] kp_q, ki_q, kd_q;
	logic [DB_W-1:0]   deadband_q;
	reg_idx_t          cfg_idx;
	logic              cfg_wr;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q       <= '0;
			ki_q       <= '0;
			kd_q       <= '0;
			deadband_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_KP:       kp_q       <= pwdata[GAIN_W-1:0];
				REG_KI:       ki_q       <= pwdata[GAIN_W-1:0];
				REG_KD:       kd_q       <= pwdata[GAIN_W-1:0];
				REG_DEADBAND: deadband_q <= pwdata[DB_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_KP:       prdata = APB_DATA_W'(kp_q);
			REG_KI:       prdata = APB_DATA_W'(ki_q);
			REG_KD:       prdata = APB_DATA_W'(kd_q);
			REG_DEADBAND: prdata = APB_DATA_W'(deadband_q);
			default:      prdata = '0;
		endcase
	end

	// flow control
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic adv2, adv3, adv4;

	assign adv4     = !valid_s4 || m_tready;
	assign adv3     = !valid_s3 || adv4;
	assign adv2     = !valid_s2 || adv3;
	assign s_tready = !valid_s1 || adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (adv2)     valid_s2 <= valid_s1;
			if (adv3)     valid_s3 <= valid_s2;
			if (adv4)     valid_s4 <= valid_s3;
		end
	end

	// stage 1: error and window flags
	logic signed [DATA_WIDTH-1:0] sp_c, meas_c;
	logic signed [ERR_W-1:0]      err_c;
	logic signed [CMP_W-1:0]      err_x, db_x, win_x;
	logic signed [ERR_W-1:0]      err_s1;
	logic                         in_db_s1, in_win_s1;

	assign sp_c   = s_tdata[DATA_WIDTH-1:0];
	assign meas_c = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
	assign err_c  = ERR_W'(sp_c) - ERR_W'(meas_c);
	assign err_x  = CMP_W'(err_c);
	assign db_x   = CMP_W'(deadband_q);
	assign win_x  = CMP_W'({deadband_q, 2'b00}) + CMP_W'({deadband_q, 1'b0});

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			err_s1    <= err_c;
			in_db_s1  <= (err_x < db_x) && (err_x > -db_x);
			in_win_s1 <= (err_x < win_x) && (err_x > -win_x);
		end
	end

	// stage 2: integral and derivative state
	logic signed [SUM_W-1:0] sum_q;
	logic signed [ERR_W-1:0] prev_q;
	logic signed [ACC_W-1:0] acc_c;
	logic signed [SUM_W-1:0] acc_sat_c, sum_nxt_c;
	logic signed [ERR_W-1:0] err_eff_c, prev_eff_c;
	logic                    acc_ovf_c;
	logic signed [ERR_W-1:0] err_s2;
	logic signed [SUM_W-1:0] sum_s2;
	logic signed [DER_W-1:0] der_s2;
	logic                    take2;

	assign take2      = valid_s1 && adv2;
	assign acc_c      = ACC_W'(sum_q) + ACC_W'(err_s1);
	assign acc_ovf_c  = !((&acc_c[ACC_W-1:SUM_W-1]) || !(|acc_c[ACC_W-1:SUM_W-1]));
	assign acc_sat_c  = !acc_ovf_c ? acc_c[SUM_W-1:0] :
		acc_c[ACC_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
	assign sum_nxt_c  = (in_db_s1 || !in_win_s1) ? '0 : acc_sat_c;
	assign err_eff_c  = in_db_s1 ? '0 : err_s1;
	assign prev_eff_c = in_db_s1 ? '0 : prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			prev_q <= '0;
		end else if (take2) begin
			sum_q  <= sum_nxt_c;
			prev_q <= err_eff_c;
		end
	end

	always_ff @(posedge clk) begin
		if (take2) begin
			err_s2 <= err_eff_c;
			sum_s2 <= sum_nxt_c;
			der_s2 <= DER_W'(err_eff_c) - DER_W'(prev_eff_c);
		end
	end

	// stage 3: gain products
	logic signed [PP_W-1:0] prod_p_s3;
	logic signed [PI_W-1:0] prod_i_s3;
	logic signed [PD_W-1:0] prod_d_s3;

	always_ff @(posedge clk) begin
		if (valid_s2 && adv3) begin
			prod_p_s3 <= $signed(kp_q) * err_s2;
			prod_i_s3 <= $signed(ki_q) * sum_s2;
			prod_d_s3 <= $signed(kd_q) * der_s2;
		end
	end

	// stage 4: scale, combine, saturate
	logic signed [DACC_W-1:0]  dacc_c;
	logic                      dovf_c;
	logic signed [DRIVE_W-1:0] drive_c;
	logic [DRIVE_W-1:0]        drive_s4;

	assign dacc_c  = DACC_W'(prod_p_s3 >>> FRAC_BITS) + DACC_W'(prod_i_s3 >>> FRAC_BITS)
		+ DACC_W'(prod_d_s3 >>> FRAC_BITS);
	assign dovf_c  = !((&dacc_c[DACC_W-1:DRIVE_W-1]) || !(|dacc_c[DACC_W-1:DRIVE_W-1]));
	assign drive_c = !dovf_c ? dacc_c[DRIVE_W-1:0] :
		dacc_c[DACC_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}} : {1'b0, {(DRIVE_W-1){1'b1}}};

	always_ff @(posedge clk) begin
		if (valid_s3 && adv4) begin
			drive_s4 <= drive_c;
		end
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = drive_s4;

endmodule

`default_nettype wire

### sv/pdiw_checker.sv
// Port-level checker for pid_deadband_integral_window_unit, with its bind.
// Depends on pdiw_pkg and the top level's port list.
`timescale 1ns / 1ps
`default_nettype none

module pdiw_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tready,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic                            psel,
	input wire logic                            penable,
	input wire logic                            pwrite,
	input wire logic [pdiw_pkg::APB_ADDR_W-1:0] paddr,
	input wire logic [pdiw_pkg::APB_DATA_W-1:0] pwdata,
	input wire logic [pdiw_pkg::APB_DATA_W-1:0] prdata
);
	import pdiw_pkg::*;

	// hold a stalled output transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output transaction dropped while stalled");

	// empty output stage means the whole pipe can advance
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// read back a gain just written
	a_kp_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && !pwrite && paddr[APB_ADDR_W-1:2] == REG_KP && $past(arst_n)
			&& $past(psel && penable && pwrite && paddr[APB_ADDR_W-1:2] == REG_KP))
		|-> prdata[GAIN_W-1:0] == $past(pwdata[GAIN_W-1:0]))
		else $error("kp readback mismatch");

	// deadband reads back within its width
	a_db_width: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && paddr[APB_ADDR_W-1:2] == REG_DEADBAND
		|-> prdata[APB_DATA_W-1:DB_W] == '0)
		else $error("deadband readback exceeds its width");

endmodule

bind pid_deadband_integral_window_unit pdiw_checker u_pdiw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata)
);

`default_nettype wire

### tb/pid_deadband_integral_window_unit_checker.sv
// Checker for the PID deadband/integral-window unit: predicts every drive value
// from the input and register transactions it observes and compares the output stream.
// Depends on pdiw_pkg.
`timescale 1ns / 1ps

module pid_deadband_integral_window_unit_checker #(
	parameter int DATA_WIDTH = pdiw_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = pdiw_pkg::FRAC_BITS_DEF,
	localparam int IN_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [IN_TDATA_W-1:0]           s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [pdiw_pkg::DRIVE_W-1:0]    m_tdata,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [pdiw_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [pdiw_pkg::APB_DATA_W-1:0] pwdata,
	output int                              mismatch_count,
	output int                              drives_pending
);
	import pdiw_pkg::*;

	logic signed [GAIN_W-1:0] gain_p;
	logic signed [GAIN_W-1:0] gain_i;
	logic signed [GAIN_W-1:0] gain_d;
	logic [DB_W-1:0]          band;
	longint                   sum_acc;
	longint                   last_err;
	logic [DRIVE_W-1:0]       drive_expected[$];
	logic [DRIVE_W-1:0]       want;
	int                       fails;

	function automatic longint saturate(longint v, int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic logic [DRIVE_W-1:0] predict_drive(
		logic signed [DATA_WIDTH-1:0] sp,
		logic signed [DATA_WIDTH-1:0] meas
	);
		longint err;
		longint db;
		longint win;
		longint deriv;
		longint acc;
		err = longint'(sp) - longint'(meas);
		db  = longint'(band);
		win = db * WINDOW_FACTOR;
		if (err < db && err > -db) begin
			err      = 0;
			sum_acc  = 0;
			last_err = 0;
		end
		if (err < win && err > -win)
			sum_acc = saturate(sum_acc + err, SUM_W);
		else
			sum_acc = 0;
		deriv    = err - last_err;
		last_err = err;
		acc = ((longint'(gain_p) * err) >>> FRAC_BITS)
		    + ((longint'(gain_i) * sum_acc) >>> FRAC_BITS)
		    + ((longint'(gain_d) * deriv) >>> FRAC_BITS);
		return DRIVE_W'(saturate(acc, DRIVE_W));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p   = '0;
			gain_i   = '0;
			gain_d   = '0;
			band     = '0;
			sum_acc  = 0;
			last_err = 0;
			fails    = 0;
			drive_expected.delete();
			mismatch_count <= 0;
			drives_pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
					REG_KP:       gain_p = pwdata[GAIN_W-1:0];
					REG_KI:       gain_i = pwdata[GAIN_W-1:0];
					REG_KD:       gain_d = pwdata[GAIN_W-1:0];
					REG_DEADBAND: band   = pwdata[DB_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				drive_expected.push_back(predict_drive(s_tdata[DATA_WIDTH-1:0],
					s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]));
			if (m_tvalid && m_tready) begin
				if (drive_expected.size() == 0) begin
					fails++;
					$display("%0t: drive with none pending, expected none, actual %0d",
						$time, $signed(m_tdata));
				end else begin
					want = drive_expected.pop_front();
					if (m_tdata !== want) begin
						fails++;
						$display("%0t: drive mismatch, expected %0d, actual %0d",
							$time, $signed(want), $signed(m_tdata));
					end
				end
			end
			mismatch_count <= fails;
			drives_pending <= drive_expected.size();
		end
	end

endmodule

### tb/pid_deadband_integral_window_unit_test.sv
// Top of the PID deadband/integral-window testbench: clock, reset, register writes,
// sample stream and output backpressure; the checker beside the block predicts and compares.
// Depends on pdiw_pkg, pid_deadband_integral_window_unit and its checker.
`timescale 1ns / 1ps

module pid_deadband_integral_window_unit_test;
	import pdiw_pkg::*;

	localparam int DW           = DATA_WIDTH_DEF;
	localparam int IN_W         = ((2 * DW + 7) / 8) * 8;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int FLUSH_CYCLES = 8;
	localparam int PHASE_ITEMS  = 40;
	localparam int SAT_ITEMS    = 260;

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [DRIVE_W-1:0]    m_tdata;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int mismatch_count;
	int drives_pending;
	int cycles     = 0;
	int stall_left = 0;
	int cur_band   = 0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;

	pid_deadband_integral_window_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	pid_deadband_integral_window_unit_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.mismatch_count (mismatch_count),
		.drives_pending (drives_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("pid_deadband_integral_window_unit_test failed");
			$finish;
		end
	end

	// hold off the output side in random bursts
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (rx_idle_on && $urandom_range(5, 0) == 0)
			stall_left = $urandom_range(11, 1);
		m_tready <= (stall_left == 0);
	end

	task automatic apb_write(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (drives_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
		logic [GAIN_W-1:0] kd, logic [DB_W-1:0] db);
		logic [31:0] junk;
		drain();
		junk = $urandom();
		apb_write(REG_KP, {junk[31:16], kp});
		junk = $urandom();
		apb_write(REG_KI, {junk[31:16], ki});
		junk = $urandom();
		apb_write(REG_KD, {junk[31:16], kd});
		junk = $urandom();
		apb_write(REG_DEADBAND, {junk[31:15], db});
		cur_band = int'(db);
	endtask

	task automatic send_pair(logic [DW-1:0] sp, logic [DW-1:0] meas);
		if (tx_idle_on && $urandom_range(4, 0) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(11, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'({meas, sp});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// place a given error anywhere in the legal setpoint/measurement range
	task automatic send_err(int e);
		int lo;
		int hi;
		int meas;
		lo   = (e > 0) ? -32768 : -32768 - e;
		hi   = (e > 0) ? 32767 - e : 32767;
		meas = lo + int'($urandom_range(hi - lo, 0));
		send_pair(DW'(meas + e), DW'(meas));
	endtask

	function automatic int pick_err(int db);
		int mode;
		int mag;
		mode = $urandom_range(9, 0);
		if (mode < 2)
			return int'($urandom_range(131070, 0)) - 65535;
		case (mode)
			2:       mag = db + int'($urandom_range(2, 0)) - 1;
			3:       mag = WINDOW_FACTOR * db + int'($urandom_range(2, 0)) - 1;
			4, 5, 6: mag = (db > 0) ? db + int'($urandom_range(5 * db - 1, 0))
			                        : int'($urandom_range(20, 0));
			7:       mag = (db > 0) ? int'($urandom_range(db - 1, 0)) : 0;
			default: mag = int'($urandom_range(300, 0));
		endcase
		if (mag < 0)
			mag = 0;
		if (mag > 65535)
			mag = 65535;
		return ($urandom_range(1, 0) == 1) ? -mag : mag;
	endfunction

	initial begin
		int p;
		int i;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gains and zero deadband
		send_pair(16'h7fff, 16'h8000);
		send_pair(16'h8000, 16'h7fff);
		send_pair(16'h0000, 16'h0000);

		configure(16'sd256, 16'sd256, 16'sd256, 15'd10);
		send_pair(16'sd0, 16'sd0);
		send_pair(16'sd5, 16'sd0);
		send_pair(16'sd10, 16'sd0);
		send_pair(16'sd0, 16'sd10);
		send_pair(16'sd9, 16'sd0);
		send_pair(16'sd0, 16'sd9);
		send_pair(16'sd59, 16'sd0);
		send_pair(16'sd59, 16'sd0);
		send_pair(16'sd60, 16'sd0);
		send_pair(16'sd0, 16'sd59);
		send_pair(16'sd0, 16'sd60);
		send_pair(16'sd0, 16'sd61);
		send_pair(16'h7fff, 16'h8000);
		send_pair(16'h8000, 16'h7fff);
		send_pair(16'h7fff, 16'h7fff);
		send_pair(16'h8000, 16'h8000);
		send_pair(16'hffff, 16'h0000);
		send_pair(16'h0000, 16'hffff);
		send_pair(16'sd1000, 16'sd0);
		send_pair(16'sd1000, 16'sd0);

		for (p = 0; p < 6; p++) begin
			case (p)
				0: configure(16'sd256, 16'sd16, 16'sd64, 15'd100);
				1: configure(16'h7fff, 16'h7fff, 16'h7fff, 15'h7fff);
				2: configure(16'h8000, 16'h8000, 16'h8000, 15'd0);
				3: configure(GAIN_W'($urandom()), GAIN_W'($urandom()),
					GAIN_W'($urandom()), 15'd1);
				4: configure(GAIN_W'($urandom()), GAIN_W'($urandom()),
					GAIN_W'($urandom()), DB_W'($urandom_range(2000, 1)));
				default: configure(GAIN_W'($urandom()), GAIN_W'($urandom()),
					GAIN_W'($urandom()), DB_W'($urandom()));
			endcase
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (i == 0 || i == PHASE_ITEMS / 2) begin
					tx_idle_on = ($urandom_range(3, 0) != 0);
					rx_idle_on = ($urandom_range(3, 0) != 0);
				end
				send_err(pick_err(cur_band));
			end
		end

		// drive the output into both saturation bounds, no idling
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		configure(16'h7fff, 16'h7fff, GAIN_W'($urandom()), 15'h7fff);
		for (i = 0; i < SAT_ITEMS; i++)
			send_err(int'($urandom_range(65535, 65000)));
		send_err(0);
		for (i = 0; i < SAT_ITEMS; i++)
			send_err(-int'($urandom_range(65535, 65000)));

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (drives_pending != 0) @(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("pid_deadband_integral_window_unit_test passed");
		else
			$display("pid_deadband_integral_window_unit_test failed");
		$finish;
	end

endmodule

### filelist.f
sv/pdiw_pkg.sv
sv/pid_deadband_integral_window_unit.sv
sv/pdiw_checker.sv
tb/pid_deadband_integral_window_unit_checker.sv
tb/pid_deadband_integral_window_unit_test.sv
